FILE: sv/fds_pkg.sv
// Shared types and constants of the fan duty scheduler.
`timescale 1ns / 1ps
package fds_pkg;

   // Operating modes held in the mode register.
   typedef enum logic [1:0] {
      MODE_MANUAL = 2'd0,
      MODE_AUTO   = 2'd1,
      MODE_PROG   = 2'd2,
      MODE_OFF    = 2'd3
   } mode_type;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_OP_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MANUAL_DUTY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_LOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT0       = 3'd4;

   // Field widths and constants.
   localparam int TEMP_W      = 16;
   localparam int DUTY_W      = 7;
   localparam int MIN_W       = 11;
   localparam int DEN_W       = 16;
   localparam int REM_W       = 23;
   localparam int QUO_W       = 7;
   localparam int SLOT_IDX_W  = 2;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
   localparam logic [MIN_W-1:0]  MIN_PER_HOUR = 11'd60;

   // One input item.
   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     presence;
      logic [2:0]               weekday;
      logic [4:0]               hour;
      logic [5:0]               minute;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [DUTY_W-1:0]     duty_percent;
      logic                  schedule_hit;
      logic [SLOT_IDX_W-1:0] hit_slot;
   } rsp_type;

   // Packing of one schedule slot register, most significant field first.
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_high;
      logic signed [TEMP_W-1:0] temp_low;
      logic [1:0]               spare;
      logic [MIN_W-1:0]         end_min;
      logic [MIN_W-1:0]         start_min;
      logic [6:0]               day_mask;
      logic                     active;
   } slot_type;

   // Item after mode and slot selection.
   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic signed [TEMP_W-1:0] temp_low;
      logic signed [TEMP_W-1:0] temp_high;
      logic                     fixed;
      logic [DUTY_W-1:0]        fixed_duty;
      logic                     hit;
      logic [SLOT_IDX_W-1:0]    hit_slot;
   } sel_type;

   // Item inside the ramp divider.
   typedef struct packed {
      logic [REM_W-1:0]      rem;
      logic [DEN_W-1:0]      den;
      logic [QUO_W-1:0]      quo;
      logic                  fixed;
      logic [DUTY_W-1:0]     fixed_duty;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_slot;
   } div_type;

endpackage

FILE: sv/fds_front.sv
// Time of day, mode decode and schedule slot match (two stages).
`timescale 1ns / 1ps
module fds_front #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  fds_pkg::req_type                    in_data,
   input  fds_pkg::mode_type                   op_mode,
   input  logic [fds_pkg::DUTY_W-1:0]          manual_duty,
   input  logic signed [fds_pkg::TEMP_W-1:0]   auto_temp_low,
   input  logic signed [fds_pkg::TEMP_W-1:0]   auto_temp_high,
   input  fds_pkg::slot_type                   slots [NUM_SLOTS],
   output logic                                out_valid,
   output fds_pkg::sel_type                    out_data
);
   import fds_pkg::*;

   logic                     v1_ff;
   logic signed [TEMP_W-1:0] temp1_ff;
   logic                     pres1_ff;
   logic [2:0]               day1_ff;
   logic [MIN_W-1:0]         now1_ff;
   logic [MIN_W-1:0]         now1_in;
   logic                     v2_ff;
   sel_type                  sel2_ff;
   sel_type                  sel2_in;

   // Current time in minutes since midnight.
   assign now1_in = MIN_W'(in_data.hour) * MIN_PER_HOUR + MIN_W'(in_data.minute);

   // Stage one registers the reading and the time.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         temp1_ff <= in_data.temperature;
         pres1_ff <= in_data.presence;
         day1_ff  <= in_data.weekday;
         now1_ff  <= now1_in;
      end
   end

   // Stage two picks the thresholds or a fixed duty from the mode and slots.
   always_comb begin
      logic                  found;
      logic [SLOT_IDX_W-1:0] found_idx;
      logic                  day_ok;
      logic                  win_ok;
      slot_type              s;
      found     = 1'b0;
      found_idx = '0;
      s         = slots[0];
      for (int i = 0; i < NUM_SLOTS; i++) begin
         day_ok = (day1_ff != 3'd0) && slots[i].day_mask[day1_ff - 3'd1];
         if (slots[i].start_min <= slots[i].end_min) begin
            win_ok = (now1_ff >= slots[i].start_min) && (now1_ff <= slots[i].end_min);
         end else begin
            win_ok = (now1_ff >= slots[i].start_min) || (now1_ff <= slots[i].end_min);
         end
         if (!found && slots[i].active && day_ok && win_ok) begin
            found     = 1'b1;
            found_idx = SLOT_IDX_W'(i);
            s         = slots[i];
         end
      end

      sel2_in.temperature = temp1_ff;
      sel2_in.temp_low    = auto_temp_low;
      sel2_in.temp_high   = auto_temp_high;
      sel2_in.fixed       = 1'b1;
      sel2_in.fixed_duty  = '0;
      sel2_in.hit         = 1'b0;
      sel2_in.hit_slot    = '0;
      unique case (op_mode)
         MODE_MANUAL: begin
            sel2_in.fixed_duty = (manual_duty > DUTY_FULL) ? DUTY_FULL : manual_duty;
         end
         MODE_AUTO: begin
            sel2_in.fixed = !pres1_ff;
         end
         MODE_PROG: begin
            if (found) begin
               sel2_in.fixed     = 1'b0;
               sel2_in.temp_low  = s.temp_low;
               sel2_in.temp_high = s.temp_high;
               sel2_in.hit       = 1'b1;
               sel2_in.hit_slot  = found_idx;
            end
         end
         MODE_OFF: begin
            sel2_in.fixed = 1'b1;
         end
         default: begin
            sel2_in.fixed = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sel2_ff <= sel2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = sel2_ff;

endmodule

FILE: sv/fds_prep.sv
// Ramp end cases, differences and the scaled numerator (two stages).
`timescale 1ns / 1ps
module fds_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  fds_pkg::sel_type  in_data,
   output logic              out_valid,
   output fds_pkg::div_type  out_data
);
   import fds_pkg::*;

   logic                   v3_ff;
   div_type                d3_ff;
   div_type                d3_in;
   logic                   v4_ff;
   div_type                d4_ff;
   div_type                d4_in;
   logic signed [TEMP_W:0] diff;
   logic signed [TEMP_W:0] span;

   // Stage three settles the clamped cases and forms both differences.
   always_comb begin
      diff = (TEMP_W+1)'(in_data.temperature) - (TEMP_W+1)'(in_data.temp_low);
      span = (TEMP_W+1)'(in_data.temp_high) - (TEMP_W+1)'(in_data.temp_low);
      d3_in.rem        = REM_W'(diff[DEN_W-1:0]);
      d3_in.den        = span[DEN_W-1:0];
      d3_in.quo        = '0;
      d3_in.fixed      = in_data.fixed;
      d3_in.fixed_duty = in_data.fixed_duty;
      d3_in.hit        = in_data.hit;
      d3_in.hit_slot   = in_data.hit_slot;
      if (!in_data.fixed) begin
         if (in_data.temperature <= in_data.temp_low) begin
            d3_in.fixed      = 1'b1;
            d3_in.fixed_duty = '0;
         end else if (in_data.temperature >= in_data.temp_high) begin
            d3_in.fixed      = 1'b1;
            d3_in.fixed_duty = DUTY_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d3_ff <= d3_in;
      end
   end

   // Stage four scales the difference to percent.
   always_comb begin
      d4_in     = d3_ff;
      d4_in.rem = d3_ff.rem * REM_W'(DUTY_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (enable) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d4_ff <= d4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = d4_ff;

endmodule

FILE: sv/fds_div_step.sv
// One restoring division stage that settles one quotient bit.
`timescale 1ns / 1ps
module fds_div_step #(
   parameter int SHIFT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  fds_pkg::div_type  in_data,
   output logic              out_valid,
   output fds_pkg::div_type  out_data
);
   import fds_pkg::*;

   logic               v_ff;
   div_type            d_ff;
   div_type            d_in;
   logic [REM_W:0]     trial;

   // Subtract the shifted divisor when it fits in the remainder.
   always_comb begin
      trial = {1'b0, in_data.rem} - ((REM_W+1)'(in_data.den) << SHIFT);
      d_in  = in_data;
      if (!trial[REM_W]) begin
         d_in.rem        = trial[REM_W-1:0];
         d_in.quo[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (enable) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

FILE: sv/fan_duty_scheduler.sv
// Top level of the fan duty scheduler: registers, pipeline and result register.
`timescale 1ns / 1ps
// Turns each item (temperature, presence, weekday, hour, minute) into one fan
// duty of 0 to 100 percent, in manual, auto, programmed or off mode. The block
// takes one item every cycle unless the result side stalls. Two stages decode
// the time and match the schedule slots, two form the ramp numerator and
// divisor, seven stages of the restoring divider each settle one quotient bit,
// and one result register holds the item for the output side. A stall on the
// result side holds the whole pipeline. The user must write configuration
// through the csr_ port while no item is in flight; the block does not check.
module fan_duty_scheduler #(
   parameter int NUM_SLOTS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  fds_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output fds_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [fds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fds_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fds_pkg::*;

   localparam int DIV_STAGES = QUO_W;

   mode_type                 op_mode_ff;
   logic [DUTY_W-1:0]        manual_duty_ff;
   logic signed [TEMP_W-1:0] auto_low_ff;
   logic signed [TEMP_W-1:0] auto_high_ff;
   slot_type                 slot_ff [NUM_SLOTS];

   logic                     advance;
   logic                     sel_valid;
   sel_type                  sel_data;
   logic                     div_valid [DIV_STAGES+1];
   div_type                  div_data  [DIV_STAGES+1];
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff     <= MODE_MANUAL;
         manual_duty_ff <= '0;
         auto_low_ff    <= '0;
         auto_high_ff   <= '0;
      end else if (csr_write) begin
         if (csr_index == REG_OP_MODE) begin
            op_mode_ff <= mode_type'(csr_wdata[1:0]);
         end
         if (csr_index == REG_MANUAL_DUTY) begin
            manual_duty_ff <= csr_wdata[DUTY_W-1:0];
         end
         if (csr_index == REG_AUTO_LOW) begin
            auto_low_ff <= csr_wdata[TEMP_W-1:0];
         end
         if (csr_index == REG_AUTO_HIGH) begin
            auto_high_ff <= csr_wdata[TEMP_W-1:0];
         end
      end
   end

   // Schedule slot registers.
   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            slot_ff[g] <= '0;
         end else if (csr_write &&
                      csr_index == REG_SLOT0 + CSR_INDEX_W'(g)) begin
            slot_ff[g] <= csr_wdata;
         end
      end
   end

   // The whole pipeline moves while the result register is free or drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   fds_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .in_valid       (req_valid),
      .in_data        (req_data),
      .op_mode        (op_mode_ff),
      .manual_duty    (manual_duty_ff),
      .auto_temp_low  (auto_low_ff),
      .auto_temp_high (auto_high_ff),
      .slots          (slot_ff),
      .out_valid      (sel_valid),
      .out_data       (sel_data)
   );

   fds_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (sel_valid),
      .in_data   (sel_data),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   // Divider stages from the top quotient bit down.
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      fds_div_step #(
         .SHIFT (DIV_STAGES - 1 - j)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (div_valid[j]),
         .in_data   (div_data[j]),
         .out_valid (div_valid[j+1]),
         .out_data  (div_data[j+1])
      );
   end

   // Result register.
   always_comb begin
      rsp_in.duty_percent = div_data[DIV_STAGES].fixed ?
                            div_data[DIV_STAGES].fixed_duty :
                            DUTY_W'(div_data[DIV_STAGES].quo);
      rsp_in.schedule_hit = div_data[DIV_STAGES].hit;
      rsp_in.hit_slot     = div_data[DIV_STAGES].hit_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the fan duty scheduler: a directed plan, then random phases.
`timescale 1ns / 1ps
module tb_top;
   import fds_pkg::*;

   localparam int NUM_SLOTS     = 4;
   localparam int PIPE_LATENCY  = 12;
   localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
   localparam int NUM_PHASES    = 26;
   localparam int DAY_MINUTES   = 1440;
   // Highest time of day that hour and minute can both express (31:59).
   localparam int LAST_NOW      = 1919;

   // Kinds of rows in the directed plan.
   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_READING,
      ROW_READING_KNOWN
   } row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  wdata;
      req_type                reading;
      rsp_type                known;
   } plan_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Our own copy of the register file, updated on every write.
   mode_type                 cur_mode      = MODE_MANUAL;
   logic [DUTY_W-1:0]        cur_manual    = '0;
   logic signed [TEMP_W-1:0] cur_auto_low  = '0;
   logic signed [TEMP_W-1:0] cur_auto_high = '0;
   slot_type                 cur_slot [NUM_SLOTS] = '{default: '0};

   rsp_type duty_queue [$];
   int      mismatches = 0;
   bit      send_gaps  = 1'b0;
   bit      rsp_stalls = 1'b0;
   int      stall_left = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   fan_duty_scheduler #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Linear ramp between two thresholds, truncated toward zero.
   function automatic logic [DUTY_W-1:0] ramp_duty(input logic signed [TEMP_W-1:0] t,
                                                   input logic signed [TEMP_W-1:0] lo,
                                                   input logic signed [TEMP_W-1:0] hi);
      longint rise;
      longint span;
      if (t <= lo) return '0;
      if (t >= hi) return DUTY_FULL;
      rise = (longint'(t) - longint'(lo)) * longint'(DUTY_FULL);
      span = longint'(hi) - longint'(lo);
      return DUTY_W'(rise / span);
   endfunction

   // Inclusive minute window; a start later than the end wraps past midnight.
   function automatic bit window_has(input int now, input int st, input int en);
      if (st <= en) return (now >= st) && (now <= en);
      return (now >= st) || (now <= en);
   endfunction

   // Duty, hit flag and slot index that the block should return for one reading.
   function automatic rsp_type predict_duty(input req_type r);
      rsp_type  res;
      slot_type s;
      int       now;
      int       i;
      bit       found;
      res   = '0;
      found = 1'b0;
      case (cur_mode)
         MODE_MANUAL: begin
            res.duty_percent = (cur_manual > DUTY_FULL) ? DUTY_FULL : cur_manual;
         end
         MODE_AUTO: begin
            if (r.presence)
               res.duty_percent = ramp_duty(r.temperature, cur_auto_low, cur_auto_high);
         end
         MODE_PROG: begin
            now = int'(r.hour) * int'(MIN_PER_HOUR) + int'(r.minute);
            for (i = 0; i < NUM_SLOTS; i++) begin
               s = cur_slot[i];
               if (!found && s.active && r.weekday != 0 && s.day_mask[r.weekday - 1] &&
                   window_has(now, int'(s.start_min), int'(s.end_min))) begin
                  res.duty_percent = ramp_duty(r.temperature, s.temp_low, s.temp_high);
                  res.schedule_hit = 1'b1;
                  res.hit_slot     = SLOT_IDX_W'(i);
                  found            = 1'b1;
               end
            end
         end
         default: begin
            res = '0;
         end
      endcase
      return res;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] slot_word(input bit act, input logic [6:0] days,
                                                       input int st, input int en,
                                                       input int lo, input int hi);
      slot_type s;
      s           = '0;
      s.active    = act;
      s.day_mask  = days;
      s.start_min = MIN_W'(st);
      s.end_min   = MIN_W'(en);
      s.temp_low  = TEMP_W'(lo);
      s.temp_high = TEMP_W'(hi);
      return s;
   endfunction

   function automatic req_type make_reading(input int t, input bit p, input int wd,
                                            input int hr, input int mn);
      req_type r;
      r.temperature = TEMP_W'(t);
      r.presence    = p;
      r.weekday     = 3'(wd);
      r.hour        = 5'(hr);
      r.minute      = 6'(mn);
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] d);
      return '{ROW_WRITE, idx, d, '0, '0};
   endfunction

   function automatic plan_row_type item_row(input req_type r);
      return '{ROW_READING, '0, '0, r, '0};
   endfunction

   function automatic plan_row_type known_row(input req_type r, input int d, input bit h,
                                              input int k);
      rsp_type e;
      e.duty_percent = DUTY_W'(d);
      e.schedule_hit = h;
      e.hit_slot     = SLOT_IDX_W'(k);
      return '{ROW_READING_KNOWN, '0, '0, r, e};
   endfunction

   // Threshold pair: mostly an ordinary ramp, sometimes extremes, equal or inverted.
   function automatic void pick_pair(output int lo, output int hi);
      case ($urandom_range(0, 9))
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            lo = int'($signed(16'($urandom)));
            hi = lo;
         end
         2: begin
            lo = int'($signed(16'($urandom)));
            hi = int'($signed(16'($urandom)));
         end
         3: begin
            lo = int'($urandom_range(0, 16'h4000));
            hi = lo + int'($urandom_range(1, 4));
         end
         default: begin
            lo = int'($urandom_range(0, 16'h5000)) - 16'h1000;
            hi = lo + int'($urandom_range(1, 16'h1400));
         end
      endcase
   endfunction

   // Temperature near the given thresholds, with some noise and extremes.
   function automatic logic signed [TEMP_W-1:0] pick_temp(input int lo, input int hi);
      int a;
      int b;
      case ($urandom_range(0, 7))
         0: return TEMP_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2: return TEMP_W'(lo);
         3: return TEMP_W'(hi);
         default: begin
            a = ((lo < hi) ? lo : hi) - 64;
            b = ((lo < hi) ? hi : lo) + 64;
            if (a < -32768) a = -32768;
            if (b > 32767) b = 32767;
            return TEMP_W'(a + int'($urandom_range(0, b - a)));
         end
      endcase
   endfunction

   // A time inside a slot's window, its bounds included, or -1 when none is reachable.
   function automatic int pick_now(input int st, input int en);
      int a;
      int b;
      if (st <= en) begin
         a = st;
         b = (en > LAST_NOW) ? LAST_NOW : en;
      end else if ($urandom_range(0, 1) == 0 && st <= LAST_NOW) begin
         a = st;
         b = LAST_NOW;
      end else begin
         a = 0;
         b = (en > LAST_NOW) ? LAST_NOW : en;
      end
      if (a > b) return -1;
      case ($urandom_range(0, 4))
         0: return a;
         1: return b;
         default: return a + int'($urandom_range(0, b - a));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_slot_word();
      slot_type s;
      int       lo;
      int       hi;
      s        = slot_type'({$urandom, $urandom});
      s.active = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) == 0) s.day_mask = 7'h7F;
      if ($urandom_range(0, 4) != 0) begin
         s.start_min = MIN_W'($urandom_range(0, DAY_MINUTES - 1));
         s.end_min   = MIN_W'($urandom_range(0, DAY_MINUTES - 1));
      end
      pick_pair(lo, hi);
      s.temp_low  = TEMP_W'(lo);
      s.temp_high = TEMP_W'(hi);
      return s;
   endfunction

   // Random reading; in programmed mode most readings aim at one slot's day and window.
   function automatic req_type random_reading();
      req_type  r;
      slot_type s;
      int       lo;
      int       hi;
      int       k;
      int       now;
      int       tries;
      r.presence = ($urandom_range(0, 4) != 0);
      r.weekday  = 3'($urandom_range(1, 7));
      r.hour     = 5'($urandom_range(0, 23));
      r.minute   = 6'($urandom_range(0, 59));
      lo = cur_auto_low;
      hi = cur_auto_high;
      if (cur_mode == MODE_PROG) begin
         k  = $urandom_range(0, NUM_SLOTS - 1);
         s  = cur_slot[k];
         lo = s.temp_low;
         hi = s.temp_high;
         if ($urandom_range(0, 9) < 7) begin
            for (tries = 0; tries < 8 && !s.day_mask[r.weekday - 1]; tries++)
               r.weekday = 3'($urandom_range(1, 7));
            now = pick_now(int'(s.start_min), int'(s.end_min));
            if (now >= 0) begin
               r.hour   = 5'(now / 60);
               r.minute = 6'(now % 60);
            end
         end
      end
      // Occasional out-of-range day and time fields.
      if ($urandom_range(0, 9) == 0) begin
         r.weekday = 3'($urandom);
         r.hour    = 5'($urandom);
         r.minute  = 6'($urandom);
      end
      r.temperature = pick_temp(lo, hi);
      return r;
   endfunction

   // One register write, then the mirror copy follows it.
   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_OP_MODE:     cur_mode      = mode_type'(d[1:0]);
         REG_MANUAL_DUTY: cur_manual    = d[DUTY_W-1:0];
         REG_AUTO_LOW:    cur_auto_low  = d[TEMP_W-1:0];
         REG_AUTO_HIGH:   cur_auto_high = d[TEMP_W-1:0];
         default:         cur_slot[idx - REG_SLOT0] = d;
      endcase
   endtask

   // Stop sending and wait until the pipeline has returned everything.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one reading, record its expected result on acceptance, maybe idle after.
   task automatic put_reading(input req_type r, input bit known, input rsp_type e);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      duty_queue.push_back(known ? e : predict_duty(r));
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Result side: compare each accepted item with the oldest expectation, stall at random.
   always @(posedge clock) begin : collect
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_queue.size() == 0) begin
            $error("result item with no expectation: duty_percent %0d", rsp_data.duty_percent);
            mismatches++;
         end else begin
            want = duty_queue.pop_front();
            if (rsp_data.duty_percent !== want.duty_percent) begin
               $error("duty_percent: expected %0d, got %0d",
                      want.duty_percent, rsp_data.duty_percent);
               mismatches++;
            end
            if (rsp_data.schedule_hit !== want.schedule_hit) begin
               $error("schedule_hit: expected %0d, got %0d",
                      want.schedule_hit, rsp_data.schedule_hit);
               mismatches++;
            end
            if (rsp_data.hit_slot !== want.hit_slot) begin
               $error("hit_slot: expected %0d, got %0d", want.hit_slot, rsp_data.hit_slot);
               mismatches++;
            end
         end
      end
      if (stall_left > 0)
         stall_left--;
      else if (rsp_stalls && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 13);
      rsp_ready <= (stall_left == 0);
   end

   initial begin
      plan_row_type          plan [$];
      logic [CSR_DATA_W-1:0] word;
      mode_type              mode;
      int                    ph;
      int                    i;
      int                    k;
      int                    lo;
      int                    hi;

      // Directed plan: reset values, manual saturation, fan off, auto ramp edges,
      // degenerate thresholds, slot priority, inclusive and wrapped windows.
      plan.push_back(known_row(make_reading('h1900, 1, 3, 12, 0), 0, 0, 0));
      plan.push_back(csr_row(REG_MANUAL_DUTY, 64'd100));
      plan.push_back(known_row(make_reading('h1900, 1, 3, 12, 0), 100, 0, 0));
      plan.push_back(csr_row(REG_MANUAL_DUTY, 64'd127));
      plan.push_back(known_row(make_reading('h0000, 0, 5, 1, 1), 100, 0, 0));
      plan.push_back(csr_row(REG_OP_MODE, 64'(MODE_OFF)));
      plan.push_back(known_row(make_reading('h7FFF, 1, 1, 10, 0), 0, 0, 0));
      plan.push_back(csr_row(REG_AUTO_LOW, 64'h1400));
      plan.push_back(csr_row(REG_AUTO_HIGH, 64'h1E00));
      plan.push_back(csr_row(REG_OP_MODE, 64'(MODE_AUTO)));
      plan.push_back(known_row(make_reading('h7FFF, 0, 1, 10, 0), 0, 0, 0));
      plan.push_back(known_row(make_reading('h1400, 1, 1, 10, 0), 0, 0, 0));
      plan.push_back(known_row(make_reading('h1E00, 1, 1, 10, 0), 100, 0, 0));
      plan.push_back(item_row(make_reading('h1900, 1, 1, 10, 0)));
      plan.push_back(item_row(make_reading('h1401, 1, 1, 10, 0)));
      plan.push_back(known_row(make_reading('h8000, 1, 1, 10, 0), 0, 0, 0));
      plan.push_back(known_row(make_reading('h7FFF, 1, 1, 10, 0), 100, 0, 0));
      plan.push_back(csr_row(REG_AUTO_LOW, 64'h0000));
      plan.push_back(csr_row(REG_AUTO_HIGH, 64'h0000));
      plan.push_back(known_row(make_reading('h0000, 1, 2, 3, 4), 0, 0, 0));
      plan.push_back(known_row(make_reading('h0001, 1, 2, 3, 4), 100, 0, 0));
      plan.push_back(csr_row(REG_AUTO_LOW, 64'h8000));
      plan.push_back(csr_row(REG_AUTO_HIGH, 64'h7FFF));
      plan.push_back(item_row(make_reading('h0000, 1, 2, 3, 4)));
      plan.push_back(item_row(make_reading('h7FFE, 1, 2, 3, 4)));
      plan.push_back(known_row(make_reading('h8000, 1, 2, 3, 4), 0, 0, 0));
      // Slot 0 covers Monday office hours, slot 1 the night across midnight, slot 2 is
      // inactive, slot 3 holds the whole day with bounds past the last minute.
      plan.push_back(csr_row(REG_SLOT0, slot_word(1, 7'h01, 480, 1020, 'h1400, 'h1E00)));
      plan.push_back(csr_row(REG_SLOT0 + 3'd1, slot_word(1, 7'h7F, 1320, 360, 'h1000, 'h2000)));
      plan.push_back(csr_row(REG_SLOT0 + 3'd2, slot_word(0, 7'h7F, 0, 1439, 0, 'h100)));
      plan.push_back(csr_row(REG_SLOT0 + 3'd3, slot_word(1, 7'h7F, 0, 2047, 'h8000, 'h7FFF)));
      plan.push_back(csr_row(REG_OP_MODE, 64'(MODE_PROG)));
      plan.push_back(item_row(make_reading('h1900, 1, 1, 10, 0)));
      plan.push_back(item_row(make_reading('h1E00, 1, 1, 8, 0)));
      plan.push_back(item_row(make_reading('h1A00, 0, 1, 17, 0)));
      plan.push_back(item_row(make_reading('h1900, 1, 2, 10, 0)));
      plan.push_back(item_row(make_reading('h1800, 1, 7, 23, 30)));
      plan.push_back(item_row(make_reading('h1100, 1, 3, 6, 0)));
      plan.push_back(item_row(make_reading('h1F00, 1, 4, 31, 63)));
      plan.push_back(known_row(make_reading('h1900, 1, 0, 10, 0), 0, 0, 0));
      plan.push_back(csr_row(REG_SLOT0 + 3'd3, 64'd0));
      plan.push_back(known_row(make_reading('h1900, 1, 2, 10, 0), 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_gaps  = 1'b1;
      rsp_stalls = 1'b1;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain_results();
            csr_put(plan[i].idx, plan[i].wdata);
         end else begin
            put_reading(plan[i].reading, plan[i].kind == ROW_READING_KNOWN, plan[i].known);
         end
      end

      // Random phases: a fresh register set each time, then a burst of readings.
      // The last phase runs with no idling on either side.
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         send_gaps  = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_stalls = (ph < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         k = $urandom_range(0, 9);
         if (ph < 4)
            mode = mode_type'(ph[1:0]);
         else if (k == 0)
            mode = MODE_MANUAL;
         else if (k == 1)
            mode = MODE_OFF;
         else if (k < 5)
            mode = MODE_AUTO;
         else
            mode = MODE_PROG;
         word      = {$urandom, $urandom};
         word[1:0] = mode;
         csr_put(REG_OP_MODE, word);
         word = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0: word[DUTY_W-1:0] = '0;
            1: word[DUTY_W-1:0] = DUTY_FULL;
            2: word[DUTY_W-1:0] = '1;
            default: word[DUTY_W-1:0] = DUTY_W'($urandom_range(0, 127));
         endcase
         csr_put(REG_MANUAL_DUTY, word);
         pick_pair(lo, hi);
         word = {$urandom, $urandom};
         word[TEMP_W-1:0] = TEMP_W'(lo);
         csr_put(REG_AUTO_LOW, word);
         word = {$urandom, $urandom};
         word[TEMP_W-1:0] = TEMP_W'(hi);
         csr_put(REG_AUTO_HIGH, word);
         for (i = 0; i < NUM_SLOTS; i++)
            csr_put(REG_SLOT0 + CSR_INDEX_W'(i), random_slot_word());
         repeat ($urandom_range(50, 100)) put_reading(random_reading(), 1'b0, '0);
      end

      drain_results();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
